// ===== hdl/indexed_list_insert_delete_assert.svh =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_assert.svh
// Assertion macros shared by the list block: clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Types, codes and sizes shared by the indexed list controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ild_pkg;

	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

	// request kinds
	localparam logic [2:0] REQ_READ      = 3'd0;
	localparam logic [2:0] REQ_INS_FRONT = 3'd1;
	localparam logic [2:0] REQ_INS_BACK  = 3'd2;
	localparam logic [2:0] REQ_INS_AT    = 3'd3;
	localparam logic [2:0] REQ_DELETE    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_INS,
		OP_DEL
	} op_t;

	// decoded request, datapath to controller
	typedef struct packed {
		op_t  op;
		logic has_moves;
		logic last_src;
	} dp_status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_pos;
		logic shift_rd;
		logic put;
		logic cnt_inc;
		logic cnt_dec;
		logic cap_read;
		logic load_out;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ild_dp.sv =====
// ----------------------------------------------------------------------------
// ild_dp
// Datapath: entry memory, fill count, request decode, shift pointers and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_dp import ild_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0]               req_type,
	input  logic [CNT_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	input  dp_cmd_t                  cmd,
	output dp_status_t               sts,
	output logic signed [DATA_W-1:0] read_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         entry_count
);

	logic [DATA_W-1:0] entry_mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] rd_q;
	logic [1:0]        st_q;
	logic [AW-1:0]     put_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     last_q;
	logic [AW-1:0]     dst_q;
	logic              down_q;
	logic              pend_q;

	// decode results
	op_t               d_op;
	logic [1:0]        d_st;
	logic [DATA_W-1:0] d_rd;
	logic [CNT_W-1:0]  ins_pos;
	logic [CNT_W-1:0]  pos_inc;
	logic              in_range;
	logic              le_count;
	logic              full;

	logic              rd_en;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;

	assign in_range = position < count_q;
	assign le_count = position <= count_q;
	assign full     = count_q == CAP_CNT;
	assign pos_inc  = position + CNT_W'(1);

	always_comb begin
		d_op    = OP_NONE;
		d_st    = ST_DONE;
		d_rd    = '0;
		ins_pos = position;
		case (req_type)
			REQ_READ: begin
				if (in_range) begin
					d_op = OP_READ;
				end else begin
					d_st = ST_BADPOS;
					d_rd = NEG_ONE;
				end
			end
			REQ_INS_FRONT: begin
				ins_pos = '0;
				if (full) d_st = ST_FULL;
				else      d_op = OP_INS;
			end
			REQ_INS_BACK: begin
				ins_pos = count_q;
				if (full) d_st = ST_FULL;
				else      d_op = OP_INS;
			end
			REQ_INS_AT: begin
				if (!le_count) begin
					d_st = ST_BADPOS;
					d_rd = NEG_ONE;
				end else if (full) begin
					d_st = ST_FULL;
				end else begin
					d_op = OP_INS;
				end
			end
			REQ_DELETE: begin
				if (in_range) begin
					d_op = OP_DEL;
				end else begin
					d_st = ST_BADPOS;
					d_rd = NEG_ONE;
				end
			end
			default: begin
				d_st = ST_BADPOS;
			end
		endcase
	end

	assign sts.op        = d_op;
	assign sts.has_moves = (d_op == OP_INS) ? (ins_pos < count_q) : (pos_inc < count_q);
	assign sts.last_src  = src_q == last_q;

	// request registers, taken at accept; shift pointers step on shift_rd, rd_q takes read data on cap_read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q  <= value;
			rd_q   <= d_rd;
			st_q   <= d_st;
			put_q  <= ins_pos[AW-1:0];
			down_q <= d_op == OP_INS;
			if (d_op == OP_INS) begin
				src_q  <= AW'(count_q - CNT_W'(1));
				last_q <= ins_pos[AW-1:0];
			end else begin
				src_q  <= pos_inc[AW-1:0];
				last_q <= AW'(count_q - CNT_W'(1));
			end
		end else begin
			if (cmd.shift_rd) begin
				src_q <= down_q ? src_q - AW'(1) : src_q + AW'(1);
				dst_q <= down_q ? src_q + AW'(1) : src_q - AW'(1);
			end
			if (cmd.cap_read) rd_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			count_q <= '0;
		end else begin
			pend_q <= cmd.shift_rd;
			if (cmd.cnt_inc)      count_q <= count_q + CNT_W'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CNT_W'(1);
		end
	end

	// single read port, single write port
	assign rd_en = cmd.rd_pos | cmd.shift_rd;
	assign raddr = cmd.shift_rd ? src_q : position[AW-1:0];
	assign we    = pend_q | cmd.put;
	assign waddr = pend_q ? dst_q : put_q;
	assign wdata = pend_q ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= entry_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we) entry_mem[waddr] <= wdata;
	end

	// result register, held until the next load
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_value  <= rd_q;
			status      <= st_q;
			entry_count <= count_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ild_ctrl.sv =====
// ----------------------------------------------------------------------------
// ild_ctrl
// Controller: sequences one request through read, shift, put and result.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_ctrl import ild_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RCAP  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ins_q;
	logic       ins_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		ins_d   = ins_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (sts.op)
						OP_READ: begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RCAP;
						end
						OP_INS: begin
							ins_d   = 1'b1;
							state_d = sts.has_moves ? S_SHIFT : S_PUT;
						end
						OP_DEL: begin
							ins_d = 1'b0;
							if (sts.has_moves) begin
								state_d = S_SHIFT;
							end else begin
								cmd.cnt_dec = 1'b1;
								state_d     = S_DONE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RCAP: begin
				cmd.cap_read = 1'b1;
				state_d      = S_DONE;
			end
			S_SHIFT: begin
				// one entry moves per cycle; each write takes its entry from the registered read data
				cmd.shift_rd = 1'b1;
				if (sts.last_src) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (ins_q) begin
					state_d = S_PUT;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_PUT: begin
				cmd.put     = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ins_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ins_q       <= ins_d;
			out_valid_q <= cmd.load_out | (out_valid_q & ~out_ready);
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to 64 signed 32-bit entries with read, insert and
// delete by position; one result per request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. The entries live in a memory with one
// read port and one write port, so the later entries that shift are moved
// one at a time, each read and then written one place over. A read passes
// through a capture state; an insert shifts and drains when entries move,
// then puts the new entry; a delete shifts and drains, or goes straight to
// the result when the last entry is deleted; a refused or invalid request
// goes straight to the result. A new request is taken the cycle after the
// result is loaded, even while that result waits on out_ready. The entry
// memory is not cleared after reset; only the fill count is.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_list_insert_delete_assert.svh"

module indexed_list_insert_delete import ild_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               req_type,
	input  logic [CNT_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] read_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         entry_count
);

	dp_status_t sts;
	dp_cmd_t    cmd;

	ild_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ild_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.position    (position),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	`ILD_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request overlap")
	`ILD_ASSERT_SAME(a_full_count, out_valid && status == ST_FULL, entry_count == CAP_CNT,
		"full status with room left")
	`ILD_ASSERT_SAME(a_fail_value, out_valid && status != ST_DONE,
		read_value == NEG_ONE || read_value == '0, "bad value on failed request")

endmodule

`default_nettype wire
